>>> hw/rtl/mh_pkg.sv
// ----------------------------------------------------------------------------
// Magnetometer heading package
// Shared widths, fixed-point constants, CSR indexes and the arctangent table
// for the CORDIC heading pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mh_pkg;

   // Default build parameters
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int SAMPLE_WIDTH_DEF  = 16;

   // Port widths fixed by the interface
   localparam int MAG_W     = 16;
   localparam int OFS_W     = 13;
   localparam int HEAD_W    = 16;
   localparam int CSR_IDX_W = 2;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET = 2'd1;

   // Offset reset values
   localparam logic signed [OFS_W-1:0] X_OFFSET_RST = 13'sd55;
   localparam logic signed [OFS_W-1:0] Y_OFFSET_RST = 13'sd50;

   // Fixed point: angles in 2^-22 degree, components scaled by 2^24
   localparam int ANG_FRAC   = 22;
   localparam int COMP_SCALE = 24;
   localparam int TABLE_LEN  = 24;

   // Corrected sample width (largest sample plus offset, one spare bit)
   localparam int SUM_W = MAG_W + 2;
   // Component width: sum, negation, CORDIC gain (< 2.33) and scale
   localparam int COMP_W = SUM_W + 3 + COMP_SCALE;
   // Angle accumulator: about -100 to +280 degrees in 2^-22 units
   localparam int ANG_W = 32;

   localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 * (2 ** ANG_FRAC));
   localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 * (2 ** ANG_FRAC));

   // Heading scaling: hundredths of a degree
   localparam int UANG_W = ANG_W - 1;
   localparam int SCALE_W = 7;
   localparam logic [SCALE_W-1:0] HUNDRED = 7'd100;
   localparam int PROD_W = UANG_W + SCALE_W;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (ANG_FRAC - 1));
   localparam logic [HEAD_W-1:0] HEAD_WRAP = 16'd36000;

   // One word moving down the rotation chain
   typedef struct packed {
      logic                     zero;
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [ANG_W-1:0]  ang;
   } cordic_word_type;

   // atan(2^-i) in 2^-22 degree, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:       val = 32'sd188743680;
         1:       val = 32'sd111421900;
         2:       val = 32'sd58872272;
         3:       val = 32'sd29884485;
         4:       val = 32'sd15000234;
         5:       val = 32'sd7507429;
         6:       val = 32'sd3754631;
         7:       val = 32'sd1877430;
         8:       val = 32'sd938729;
         9:       val = 32'sd469366;
         10:      val = 32'sd234683;
         11:      val = 32'sd117342;
         12:      val = 32'sd58671;
         13:      val = 32'sd29335;
         14:      val = 32'sd14668;
         15:      val = 32'sd7334;
         16:      val = 32'sd3667;
         17:      val = 32'sd1833;
         18:      val = 32'sd917;
         19:      val = 32'sd458;
         20:      val = 32'sd229;
         21:      val = 32'sd115;
         22:      val = 32'sd57;
         23:      val = 32'sd29;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mh_prep.sv
// ----------------------------------------------------------------------------
// Magnetometer heading input stage
// Sign-extends the samples, adds the calibration offsets, folds the left half
// plane onto the right one and loads the first word of the rotation chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mh_prep #(
   parameter int SAMPLE_WIDTH = mh_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output      logic                                in_ready,
   input  wire logic        [mh_pkg::MAG_W-1:0]     mag_x,
   input  wire logic        [mh_pkg::MAG_W-1:0]     mag_y,
   input  wire logic signed [mh_pkg::OFS_W-1:0]     x_offset,
   input  wire logic signed [mh_pkg::OFS_W-1:0]     y_offset,
   output      logic                                out_valid,
   input  wire logic                                out_ready,
   output      mh_pkg::cordic_word_type             out_word
);
   import mh_pkg::*;

   logic signed [SUM_W-1:0]  sx, sy, sum_x, sum_y, fold_x, fold_y;
   logic signed [COMP_W-1:0] ext_x, ext_y;
   logic                     valid_ff, valid_in;
   cordic_word_type          word_ff, word_in;

   // Offset correction
   always_comb begin
      sx    = SUM_W'($signed(mag_x[SAMPLE_WIDTH-1:0]));
      sy    = SUM_W'($signed(mag_y[SAMPLE_WIDTH-1:0]));
      sum_x = sx + SUM_W'(x_offset);
      sum_y = sy + SUM_W'(y_offset);
   end

   // Left half plane: negate the vector and start at 180 degrees
   always_comb begin
      fold_x = (sum_x < 0) ? -sum_x : sum_x;
      fold_y = (sum_x < 0) ? -sum_y : sum_y;
      ext_x  = COMP_W'(fold_x);
      ext_y  = COMP_W'(fold_y);
      word_in.zero = (sum_x == '0) && (sum_y == '0);
      word_in.x    = ext_x <<< COMP_SCALE;
      word_in.y    = ext_y <<< COMP_SCALE;
      word_in.ang  = (sum_x < 0) ? HALF_TURN : '0;
   end

   // Stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mh_cell.sv
// ----------------------------------------------------------------------------
// Magnetometer heading CORDIC cell
// One vectoring micro-rotation by atan(2^-STAGE), steering y toward zero and
// accumulating the rotated angle. Cells are chained one per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mh_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output      logic                    in_ready,
   input  wire mh_pkg::cordic_word_type in_word,
   output      logic                    out_valid,
   input  wire logic                    out_ready,
   output      mh_pkg::cordic_word_type out_word
);
   import mh_pkg::*;

   localparam logic signed [ANG_W-1:0] ATAN_STEP = atan_entry(STAGE);

   logic signed [COMP_W-1:0] sh_x, sh_y;
   logic                     valid_ff, valid_in;
   cordic_word_type          word_ff, word_in;

   // Micro-rotation, direction from the sign of y
   always_comb begin
      sh_x = in_word.x >>> STAGE;
      sh_y = in_word.y >>> STAGE;
      word_in.zero = in_word.zero;
      if (in_word.y >= 0) begin
         word_in.x   = in_word.x + sh_y;
         word_in.y   = in_word.y - sh_x;
         word_in.ang = in_word.ang + ATAN_STEP;
      end else begin
         word_in.x   = in_word.x - sh_y;
         word_in.y   = in_word.y + sh_x;
         word_in.ang = in_word.ang - ATAN_STEP;
      end
   end

   // Stage handshake
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mh_post.sv
// ----------------------------------------------------------------------------
// Magnetometer heading output stage
// Wraps the angle into 0..360 degrees, scales it to hundredths of a degree
// with round-half-up and folds 36000 back to 0. Three registered steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mh_post (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output      logic                     in_ready,
   input  wire mh_pkg::cordic_word_type  in_word,
   output      logic                     out_valid,
   input  wire logic                     out_stall,
   output      logic [mh_pkg::HEAD_W-1:0] heading
);
   import mh_pkg::*;

   logic                    wrap_v_ff, scale_v_ff, out_v_ff;
   logic                    wrap_rdy, scale_rdy, out_rdy;
   logic                    wrap_zero_ff, scale_zero_ff;
   logic [UANG_W-1:0]       wrap_ang_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [HEAD_W-1:0]       head_ff;
   logic signed [ANG_W-1:0] wrap_sum;
   logic [UANG_W-1:0]       wrap_ang_in;
   logic [PROD_W-1:0]       prod_in;
   logic [HEAD_W-1:0]       head_raw, head_in;

   // Ready chain back from the output register
   assign out_rdy   = !out_v_ff || !out_stall;
   assign scale_rdy = !scale_v_ff || out_rdy;
   assign wrap_rdy  = !wrap_v_ff || scale_rdy;
   assign in_ready  = wrap_rdy;

   // Step 1: negative angles get a full turn added
   always_comb begin
      wrap_sum    = (in_word.ang < 0) ? (in_word.ang + FULL_TURN) : in_word.ang;
      wrap_ang_in = wrap_sum[UANG_W-1:0];
   end

   // Step 2: scale by 100 and add half an LSB of the result
   assign prod_in = (PROD_W'(wrap_ang_ff) * PROD_W'(HUNDRED)) + ROUND_HALF;

   // Step 3: drop fraction, fold 36000 and force zero vector to 0
   always_comb begin
      head_raw = prod_ff[ANG_FRAC +: HEAD_W];
      if (scale_zero_ff) begin
         head_in = '0;
      end else if (head_raw >= HEAD_WRAP) begin
         head_in = head_raw - HEAD_WRAP;
      end else begin
         head_in = head_raw;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_v_ff  <= 1'b0;
         scale_v_ff <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         if (wrap_rdy) begin
            wrap_v_ff <= in_valid;
         end
         if (scale_rdy) begin
            scale_v_ff <= wrap_v_ff;
         end
         if (out_rdy) begin
            out_v_ff <= scale_v_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (wrap_rdy && in_valid) begin
         wrap_ang_ff  <= wrap_ang_in;
         wrap_zero_ff <= in_word.zero;
      end
      if (scale_rdy && wrap_v_ff) begin
         prod_ff       <= prod_in;
         scale_zero_ff <= wrap_zero_ff;
      end
      if (out_rdy && scale_v_ff) begin
         head_ff <= head_in;
      end
   end

   assign out_valid = out_v_ff;
   assign heading   = head_ff;

endmodule

`default_nettype wire

>>> hw/rtl/magnetometer_heading.sv
// ----------------------------------------------------------------------------
// Magnetometer heading
// Compass heading atan2(y, x) in hundredths of a degree from one calibrated
// X/Y magnetometer sample pair, using a pipelined CORDIC.
// ----------------------------------------------------------------------------
// One sample pair is taken per clock while req_stall is low, and each word
// passes one offset/fold stage, one register per CORDIC rotation cell, then
// wrap, scale and round stages. Every stage holds its own valid bit, so
// bubbles close up under output stall and the input keeps accepting while
// results wait, until every stage holds a word; then req_stall follows
// rsp_stall in the same cycle. Offsets are written through
// the CSR port (index 0: X offset, index 1: Y offset, 13-bit signed); other
// indexes are ignored. Write offsets only while the pipe is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_heading #(
   parameter int CORDIC_STAGES = mh_pkg::CORDIC_STAGES_DEF,
   parameter int SAMPLE_WIDTH  = mh_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Sample channel
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic signed [mh_pkg::MAG_W-1:0] req_mag_x,
   input  wire logic signed [mh_pkg::MAG_W-1:0] req_mag_y,
   // Heading channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [mh_pkg::HEAD_W-1:0]       rsp_heading,
   // CSR write port
   input  wire logic                            csr_we,
   input  wire logic [mh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mh_pkg::OFS_W-1:0]        csr_wdata
);
   import mh_pkg::*;

   localparam int NUM_ROT = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   logic signed [OFS_W-1:0] x_offset_ff, y_offset_ff;
   logic                    prep_ready;
   logic                    chain_v   [0:NUM_ROT];
   logic                    chain_rdy [0:NUM_ROT];
   cordic_word_type         chain_w   [0:NUM_ROT];

   // Calibration offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff <= X_OFFSET_RST;
         y_offset_ff <= Y_OFFSET_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_X_OFFSET: x_offset_ff <= $signed(csr_wdata);
            REG_Y_OFFSET: y_offset_ff <= $signed(csr_wdata);
            default:      ;
         endcase
      end
   end

   assign req_stall = !prep_ready;

   // Offset add and half-plane fold
   mh_prep #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .mag_x     (req_mag_x),
      .mag_y     (req_mag_y),
      .x_offset  (x_offset_ff),
      .y_offset  (y_offset_ff),
      .out_valid (chain_v[0]),
      .out_ready (chain_rdy[0]),
      .out_word  (chain_w[0])
   );

   // Rotation cells
   for (genvar i = 0; i < NUM_ROT; i++) begin : g_cell
      mh_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_v[i]),
         .in_ready  (chain_rdy[i]),
         .in_word   (chain_w[i]),
         .out_valid (chain_v[i+1]),
         .out_ready (chain_rdy[i+1]),
         .out_word  (chain_w[i+1])
      );
   end

   // Wrap, scale and round
   mh_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_v[NUM_ROT]),
      .in_ready  (chain_rdy[NUM_ROT]),
      .in_word   (chain_w[NUM_ROT]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .heading   (rsp_heading)
   );

endmodule

`default_nettype wire

>>> tb/tb_magnetometer_heading.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer heading testbench
// Drives raw X/Y sample words into the CORDIC heading pipeline under
// random valid/stall gaps and checks every heading word in order against a
// bit-accurate integer CORDIC predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_magnetometer_heading;

   localparam int STAGES      = mh_pkg::CORDIC_STAGES_DEF;
   localparam int SAMPLE_BITS = mh_pkg::SAMPLE_WIDTH_DEF;
   localparam int ANG_SHIFT   = 22;   // angle unit is 2^-22 degree
   localparam int COMP_SHIFT  = 24;   // component scale
   localparam int ATAN_LEN    = 24;
   localparam int LATENCY     = ((STAGES < ATAN_LEN) ? STAGES : ATAN_LEN) + 4;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 190;

   // CSR indexes with no register behind them
   localparam logic [mh_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE_A = 2'd2;
   localparam logic [mh_pkg::CSR_IDX_W-1:0] CSR_IDX_SPARE_B = 2'd3;

   // atan(2^-i) in 2^-22 degree
   localparam longint ATAN_DEG [ATAN_LEN] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29
   };

   typedef logic signed [mh_pkg::MAG_W-1:0]  sample_type;
   typedef logic signed [mh_pkg::OFS_W-1:0]  offset_type;
   typedef logic [mh_pkg::HEAD_W-1:0]        heading_type;
   typedef logic [mh_pkg::CSR_IDX_W-1:0]     csr_idx_type;

   // Offset copy, heading predictor and in-order check
   class heading_scoreboard;
      offset_type  x_ofs;
      offset_type  y_ofs;
      heading_type headings_due[$];
      int          errors;

      function new();
         x_ofs  = mh_pkg::X_OFFSET_RST;
         y_ofs  = mh_pkg::Y_OFFSET_RST;
         errors = 0;
      endfunction

      function void apply_write(csr_idx_type idx, offset_type data);
         if (idx == mh_pkg::REG_X_OFFSET)
            x_ofs = data;
         else if (idx == mh_pkg::REG_Y_OFFSET)
            y_ofs = data;
      endfunction

      // low SAMPLE_BITS of the raw word, two's complement
      function longint widen_sample(sample_type s);
         longint v;
         v = longint'(s);
         return (v <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
      endfunction

      function heading_type predict_heading(sample_type mx, sample_type my);
         longint cx, cy, nx, ny, ang, h;
         cx = widen_sample(mx) + longint'(x_ofs);
         cy = widen_sample(my) + longint'(y_ofs);
         if (cx == 0 && cy == 0)
            return '0;
         cx  = cx <<< COMP_SHIFT;
         cy  = cy <<< COMP_SHIFT;
         ang = 0;
         // left half plane: fold over and start at 180 degrees
         if (cx < 0) begin
            cx  = -cx;
            cy  = -cy;
            ang = longint'(180) <<< ANG_SHIFT;
         end
         // vectoring rotations drive y toward zero
         for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            if (cy >= 0) begin
               nx  = cx + (cy >>> i);
               ny  = cy - (cx >>> i);
               ang = ang + ATAN_DEG[i];
            end else begin
               nx  = cx - (cy >>> i);
               ny  = cy + (cx >>> i);
               ang = ang - ATAN_DEG[i];
            end
            cx = nx;
            cy = ny;
         end
         if (ang < 0)
            ang = ang + (longint'(360) <<< ANG_SHIFT);
         if (ang < 0)
            ang = 0;
         // hundredths, round half up, 360.00 folds to zero
         h = (ang * 100 + (longint'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
         while (h >= 36000)
            h = h - 36000;
         return heading_type'(h);
      endfunction

      function void note_sample(sample_type mx, sample_type my);
         headings_due.push_back(predict_heading(mx, my));
      endfunction

      function void check_heading(heading_type got);
         heading_type want;
         if (headings_due.size() == 0) begin
            $error("heading: expected none, actual %0d", got);
            errors++;
            return;
         end
         want = headings_due.pop_front();
         if (got !== want) begin
            $error("heading: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction

      function int pending();
         return headings_due.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sample_type  req_mag_x = '0;
   sample_type  req_mag_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   heading_type rsp_heading;
   logic        csr_we    = 1'b0;
   csr_idx_type csr_index = '0;
   offset_type  csr_wdata = '0;

   bit                calm = 1'b0;   // no idling on either side while set
   heading_scoreboard sb;

   magnetometer_heading u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mag_x   (req_mag_x),
      .req_mag_y   (req_mag_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_heading (rsp_heading),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Heading side: check accepted words, random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_heading(rsp_heading);
      rsp_stall <= !calm && ($urandom_range(99) < 16);
   end

   // One sample word; valid stays up unless an idle gap follows
   // (whether a gap follows, and its length, are random)
   task automatic send_sample(input sample_type mx, input sample_type my);
      req_valid <= 1'b1;
      req_mag_x <= mx;
      req_mag_y <= my;
      do @(posedge clock); while (req_stall);
      sb.note_sample(mx, my);
      if (!calm && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // csr_we is left high; the caller lowers it after the last write
   task automatic write_reg(input csr_idx_type idx, input offset_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.apply_write(idx, val);
   endtask

   // Both offsets plus ignored writes to the spare indexes, pipe empty
   task automatic load_offsets(input offset_type xo, input offset_type yo);
      wait_drained();
      write_reg(mh_pkg::REG_X_OFFSET, xo);
      write_reg(mh_pkg::REG_Y_OFFSET, yo);
      write_reg(CSR_IDX_SPARE_A, offset_type'($urandom()));
      write_reg(CSR_IDX_SPARE_B, offset_type'($urandom()));
      csr_we <= 1'b0;
   endtask

   // Random sample mix: full range, near the origin, on an axis, near the
   // 0/360 seam or the 180 degree line, and moderate magnitudes
   task automatic pick_sample(output sample_type mx, output sample_type my);
      int k, ox, oy;
      ox = sb.x_ofs;
      oy = sb.y_ofs;
      k  = $urandom_range(99);
      if (k < 45) begin
         mx = sample_type'($urandom());
         my = sample_type'($urandom());
      end else if (k < 65) begin
         mx = sample_type'(-ox + int'($urandom_range(40)) - 20);
         my = sample_type'(-oy + int'($urandom_range(40)) - 20);
      end else if (k < 75) begin
         if ($urandom_range(1)) begin
            mx = sample_type'($urandom());
            my = sample_type'(-oy);
         end else begin
            mx = sample_type'(-ox);
            my = sample_type'($urandom());
         end
      end else if (k < 85) begin
         if ($urandom_range(1))
            mx = sample_type'($urandom_range(32767, 16000));
         else
            mx = sample_type'(-int'($urandom_range(32768, 16000)));
         my = sample_type'(-oy + int'($urandom_range(4)) - 2);
      end else begin
         mx = sample_type'(int'($urandom_range(600)) - 300);
         my = sample_type'(int'($urandom_range(600)) - 300);
      end
   endtask

   initial begin
      sample_type mx, my;
      offset_type xo, yo;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset offsets: extremes, four axes, zero vector, seam rounding
      send_sample(0, 0);
      send_sample(-55, -50);
      send_sample(32767, 32767);
      send_sample(-32768, -32768);
      send_sample(32767, -32768);
      send_sample(-32768, 32767);
      send_sample(945, -50);
      send_sample(-55, 950);
      send_sample(-1055, -50);
      send_sample(-55, -1050);
      send_sample(32767, -51);
      send_sample(-32768, -49);
      send_sample(945, 950);

      // Offset extremes
      load_offsets(-4096, 4095);
      send_sample(4096, -4095);
      send_sample(-32768, 32767);
      send_sample(32767, -32768);
      send_sample(-1, -1);
      load_offsets(4095, -4096);
      send_sample(-4095, 4096);
      send_sample(32767, 32767);
      send_sample(-32768, -32768);
      send_sample(0, 0);

      // Random phases, one offset setting each
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin xo = 0;     yo = 0;     end
            1:       begin xo = -4096; yo = -4096; end
            2:       begin xo = 4095;  yo = 4095;  end
            5:       begin xo = mh_pkg::X_OFFSET_RST; yo = mh_pkg::Y_OFFSET_RST; end
            default: begin xo = offset_type'($urandom()); yo = offset_type'($urandom()); end
         endcase
         load_offsets(xo, yo);
         calm = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // let the pipe run dry once mid-phase
            if (p == 3 && n == PHASE_ITEMS / 2)
               wait_drained();
            pick_sample(mx, my);
            send_sample(mx, my);
         end
      end
      calm = 1'b0;

      wait_drained();
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #(5_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mh_pkg.sv
hw/rtl/mh_prep.sv
hw/rtl/mh_cell.sv
hw/rtl/mh_post.sv
hw/rtl/magnetometer_heading.sv
tb/tb_magnetometer_heading.sv
